### rtl/core/sfs_pkg.sv
// sfs_pkg: shared types and constants for the sprite frame sequencer
// operation codes, register indexes, unit codes and the word structs
// no dependencies
package sfs_pkg;

	// field widths
	localparam int unsigned OP_W     = 3;
	localparam int unsigned DELTA_W  = 24;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned DELAY_W  = 24;
	localparam int unsigned ACCUM_W  = 32;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned RATE_W   = 16;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned APB_AW   = 4;
	localparam int unsigned APB_DW   = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_FRAME = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_PLAY  = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_DIR   = 3'd3;
	localparam logic [OP_W-1:0] OP_WR_DELAY  = 3'd4;

	// register indexes (word address bits)
	localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
	localparam logic [1:0] REG_PLAY_RATE   = 2'd1;
	localparam logic [1:0] REG_LOOP_MODE   = 2'd2;

	localparam logic [RATE_W-1:0] PLAY_RATE_RST = 16'd256;

	// shared add/subtract unit functions
	localparam logic ALU_ADD_SAT = 1'b0;
	localparam logic ALU_SUB     = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		logic [RATE_W-1:0]  play_rate;
		logic               loop_mode;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [DELTA_W-1:0] delta_time;
		logic [IDX_W-1:0]   frame_index;
		logic               flag_value;
		logic [DELAY_W-1:0] delay_value;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] current_frame;
		logic             playing;
		logic             reversed;
		logic             finished;
		logic             frame_event;
		logic             last;
	} res_t;

endpackage

### rtl/core/sfs_alu.sv
// sfs_alu: shared 32-bit add/subtract unit of the sequencer
// saturating accumulate for ticks, subtract with compare for frame delays
// depends on sfs_pkg
module sfs_alu import sfs_pkg::*; (
	input  logic               op,
	input  logic [ACCUM_W-1:0] a,
	input  logic [ACCUM_W-1:0] b,
	output logic [ACCUM_W-1:0] res,
	output logic               ge
);

	logic [ACCUM_W:0] sum;
	logic [ACCUM_W:0] diff;

	// one adder and one subtractor with carry out
	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};
	assign ge   = ~diff[ACCUM_W];

	// function select, add saturates at all ones
	always_comb begin
		case (op)
			ALU_ADD_SAT: res = sum[ACCUM_W] ? {ACCUM_W{1'b1}} : sum[ACCUM_W-1:0];
			ALU_SUB:     res = diff[ACCUM_W-1:0];
			default:     res = diff[ACCUM_W-1:0];
		endcase
	end

endmodule

### rtl/core/sfs_regs.sv
// sfs_regs: APB register file for frame count, play rate and loop mode
// write on access phase, read is a plain mux, pready tied high
// depends on sfs_pkg
module sfs_regs import sfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count <= '0;
			cfg_q.play_rate   <= PLAY_RATE_RST;
			cfg_q.loop_mode   <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_FRAME_COUNT: cfg_q.frame_count <= pwdata[COUNT_W-1:0];
				REG_PLAY_RATE:   cfg_q.play_rate   <= pwdata[RATE_W-1:0];
				REG_LOOP_MODE:   cfg_q.loop_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_FRAME_COUNT: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_q.frame_count};
			REG_PLAY_RATE:   prdata = {{(APB_DW-RATE_W){1'b0}}, cfg_q.play_rate};
			REG_LOOP_MODE:   prdata = {{(APB_DW-1){1'b0}}, cfg_q.loop_mode};
			default:         prdata = '0;
		endcase
	end

endmodule

### rtl/core/sfs_core.sv
// sfs_core: sequencer for ticks and control operations, holds the delay table
// uses sfs_alu for accumulate and delay compare, one frame step per cycle unless the result output stalls
// depends on sfs_pkg, sfs_alu
module sfs_core import sfs_pkg::*; #(
	parameter int unsigned MAX_FRAMES = 64,
	parameter int unsigned MAX_STEPS  = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	localparam int unsigned AW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned SCW = $clog2(MAX_STEPS + 1);
	localparam int unsigned CAP = (MAX_FRAMES > 127) ? 127 : MAX_FRAMES;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_STEP = 3'd4;
	localparam logic [2:0] S_STAT = 3'd5;

	logic [2:0]         state_q;
	logic [ACCUM_W-1:0] accum_q;
	logic [POS_W-1:0]   pos_q;
	logic               play_q;
	logic               rev_q;
	logic [SCW-1:0]     step_cnt_q;
	logic [AW-1:0]      clr_addr_q;
	logic [DELTA_W-1:0] delta_q;
	logic [ACCUM_W-1:0] prod_q;
	logic [DELAY_W-1:0] rd_data_q;
	logic [DELAY_W-1:0] mem [MAX_FRAMES];

	logic [COUNT_W-1:0]         eff_cnt;
	logic                       accept;
	logic                       tick_live;
	logic                       set_ok;
	logic                       wr_ok;
	logic [DELTA_W+RATE_W-1:0]  prod_full;
	logic                       alu_op;
	logic [ACCUM_W-1:0]         alu_b;
	logic [ACCUM_W-1:0]         alu_res;
	logic                       alu_ge;
	logic                       go;
	logic                       step_fire;
	logic [POS_W-1:0]           nxt_pos;
	logic                       nxt_rev;
	logic                       nxt_play;
	logic [AW+POS_W-1:0]        pos_ext;
	logic [AW+IDX_W-1:0]        idx_ext;
	logic [AW-1:0]              rd_addr;
	logic                       mem_we;
	logic [AW-1:0]              mem_wa;
	logic [DELAY_W-1:0]         mem_wd;

	// frame count limited to the table size and to 127
	assign eff_cnt = (cfg.frame_count > COUNT_W'(CAP)) ? COUNT_W'(CAP) : cfg.frame_count;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign tick_live = play_q & (eff_cnt > 7'd1) & (cfg.play_rate != '0);
	assign set_ok    = ({1'b0, in_item.frame_index} < eff_cnt);
	assign wr_ok     = ({{(32-IDX_W){1'b0}}, in_item.frame_index} < 32'(MAX_FRAMES));
	assign prod_full = delta_q * cfg.play_rate;

	// shared unit: accumulate in the add state, delay compare otherwise
	assign alu_op = (state_q == S_ADD) ? ALU_ADD_SAT : ALU_SUB;
	assign alu_b  = (state_q == S_ADD) ? prod_q
		: {{(ACCUM_W-DELAY_W){1'b0}}, rd_data_q};

	sfs_alu u_alu (
		.op  (alu_op),
		.a   (accum_q),
		.b   (alu_b),
		.res (alu_res),
		.ge  (alu_ge)
	);

	// step decision for the current frame
	assign go = play_q & (step_cnt_q < SCW'(MAX_STEPS)) & (rd_data_q != '0) & alu_ge;
	assign step_fire = (state_q == S_STEP) & go & ((step_cnt_q == '0) | res_ready);

	// next frame position, ping-pong or stop at the ends
	always_comb begin
		nxt_pos  = pos_q;
		nxt_rev  = rev_q;
		nxt_play = play_q;
		if (!rev_q) begin
			if (pos_q < (eff_cnt - 7'd1)) begin
				nxt_pos = pos_q + 7'd1;
			end else if (cfg.loop_mode) begin
				nxt_rev = 1'b1;
				nxt_pos = eff_cnt - 7'd2;
			end else begin
				nxt_play = 1'b0;
			end
		end else begin
			if (pos_q != '0) begin
				nxt_pos = pos_q - 7'd1;
			end else if (cfg.loop_mode) begin
				nxt_rev = 1'b0;
				nxt_pos = 7'd1;
			end else begin
				nxt_play = 1'b0;
			end
		end
	end

	// table addresses
	assign pos_ext = {{AW{1'b0}}, (step_fire ? nxt_pos : pos_q)};
	assign rd_addr = pos_ext[AW-1:0];
	assign idx_ext = {{AW{1'b0}}, in_item.frame_index};

	assign mem_we = (state_q == S_CLR) | (accept & (in_item.op == OP_WR_DELAY) & wr_ok);
	assign mem_wa = (state_q == S_CLR) ? clr_addr_q : idx_ext[AW-1:0];
	assign mem_wd = (state_q == S_CLR) ? '0 : in_item.delay_value;

	// delay table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	// result words: earlier steps while stepping, final word on stop, status word in S_STAT
	always_comb begin
		res_valid         = 1'b0;
		res.current_frame = pos_q[IDX_W-1:0];
		res.playing       = play_q;
		res.reversed      = rev_q;
		res.finished      = ~cfg.loop_mode & ~play_q;
		res.frame_event   = 1'b0;
		res.last          = 1'b1;
		case (state_q)
			S_STEP: begin
				res_valid       = go ? (step_cnt_q != '0) : 1'b1;
				res.frame_event = (step_cnt_q != '0);
				res.last        = ~go;
			end
			S_STAT: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= in_item.delta_time;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_full[DELTA_W+RATE_W-1:8];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			accum_q    <= '0;
			pos_q      <= '0;
			play_q     <= 1'b0;
			rev_q      <= 1'b0;
			step_cnt_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(MAX_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						step_cnt_q <= '0;
						if ((in_item.op == OP_TICK) && tick_live) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_STAT;
						end
						case (in_item.op)
							OP_SET_FRAME: begin
								if (set_ok) begin
									pos_q   <= {1'b0, in_item.frame_index};
									accum_q <= '0;
								end
							end
							OP_SET_PLAY: play_q <= in_item.flag_value;
							OP_SET_DIR:  rev_q  <= in_item.flag_value;
							default: ;
						endcase
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					accum_q <= alu_res;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (step_fire) begin
						accum_q    <= alu_res;
						pos_q      <= nxt_pos;
						rev_q      <= nxt_rev;
						play_q     <= nxt_play;
						step_cnt_q <= step_cnt_q + SCW'(1);
					end else if (!go && res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_STAT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// step count stays within the per-tick cap
	a_step_cap: assert property (@(posedge clk) disable iff (!arst_n)
		step_cnt_q <= SCW'(MAX_STEPS))
		else $error("step count above cap");

	// words leave only from the stepping and status states
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (state_q == S_STEP || state_q == S_STAT))
		else $error("result word outside stepping");

	// a step never consumes a zero delay
	a_no_zero_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |-> (rd_data_q != '0))
		else $error("step on zero delay");

	// a step takes exactly the frame delay off the accumulator
	a_step_sub: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> (accum_q == $past(accum_q - {{(ACCUM_W-DELAY_W){1'b0}}, rd_data_q})))
		else $error("accumulator step mismatch");

	// no item is taken while the table is being cleared
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !in_ready)
		else $error("input taken during clear");

endmodule

### rtl/core/sprite_frame_sequencer.sv
// sprite_frame_sequencer: top level, stream ports, APB port and result register
// depends on sfs_pkg, sfs_regs, sfs_core
//
// channel   direction  handshake           contents
// s_*       in         s_tvalid/s_tready   operation word (op in s_tuser)
// m_*       out        m_tvalid/m_tready   result word (frame_event in m_tuser, last in m_tlast)
// apb       in/out     psel/penable        frame_count, play_rate, loop_mode
//
// control operations are accepted, then answered with one status word
// a tick runs setup (accept, multiply, accumulate), then up to MAX_STEPS frame steps
// and the final word, paced by the shared add/subtract unit doing one delay
// compare per cycle while the result path does not stall
// after reset the delay table is cleared, s_tready stays low meanwhile
// a stalled m_tready holds the sequencer in place; the result register frees it one word early
module sprite_frame_sequencer import sfs_pkg::*; #(
	parameter int unsigned MAX_FRAMES = 64,
	parameter int unsigned MAX_STEPS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	// delta_time[23:0], frame_index[29:24], flag_value[30], delay_value[54:31], zero[55]
	input  logic [55:0]       s_tdata,
	// op[2:0]
	input  logic [2:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// current_frame[5:0], playing[6], reversed[7], finished[8], zero[15:9]
	output logic [15:0]       m_tdata,
	// frame_event[0]
	output logic [0:0]        m_tuser,
	output logic              m_tlast
);

	cfg_t  cfg;
	item_t item;
	res_t  res;
	res_t  out_q;
	logic  res_valid;
	logic  res_ready;
	logic  out_valid_q;

	sfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// unpack the input word
	assign item.op          = s_tuser;
	assign item.delta_time  = s_tdata[23:0];
	assign item.frame_index = s_tdata[29:24];
	assign item.flag_value  = s_tdata[30];
	assign item.delay_value = s_tdata[54:31];

	sfs_core #(
		.MAX_FRAMES (MAX_FRAMES),
		.MAX_STEPS  (MAX_STEPS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// result register, loads when empty or being drained
	assign res_ready = ~out_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	// pack the result word
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.finished, out_q.reversed, out_q.playing, out_q.current_frame};
	assign m_tuser  = out_q.frame_event;
	assign m_tlast  = out_q.last;

endmodule
